// File: rtl/psra_pkg.sv
`timescale 1ns / 1ps
package psra_pkg;

   localparam int FRAC_BITS   = 32;
   localparam int MAX_NODES_S = 1024;
   localparam int MAX_NODES_V = 1024;

   localparam logic [10:0] NS_MAX = 11'(MAX_NODES_S);
   localparam logic [10:0] NV_MAX = 11'(MAX_NODES_V);

   localparam logic [63:0] FX_ONE  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] FX_HALF = FX_ONE >> 1;
   localparam logic [63:0] FX_TWO  = FX_ONE << 1;
   localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] SAT_MIN = {1'b1, 63'd0};

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_DIV, OP_EMIT
   } alu_op_type;

   typedef enum logic [3:0] {
      COL_BL, COL_B, COL_BR, COL_L, COL_C, COL_R, COL_AL, COL_A, COL_AR
   } col_type;

   typedef enum logic [2:0] {
      REG_NODES_S, REG_NODES_V, REG_RATE, REG_KAPPA, REG_THETA, REG_XI, REG_RHO
   } csr_reg_type;

   typedef enum logic [2:0] {
      SQ_IDLE, SQ_DECODE, SQ_FETCH, SQ_OPER, SQ_WAIT, SQ_EMIT
   } seq_state_type;

   typedef enum logic [2:0] {
      ALU_IDLE, ALU_MUL, ALU_MFIN, ALU_DIV
   } alu_state_type;

   typedef logic [5:0] opnd_type;

   // scratch slots
   localparam opnd_type T_HSM   = 6'd0;
   localparam opnd_type T_HSP   = 6'd1;
   localparam opnd_type T_HVM   = 6'd2;
   localparam opnd_type T_HVP   = 6'd3;
   localparam opnd_type T_DS    = 6'd4;
   localparam opnd_type T_DV    = 6'd5;
   localparam opnd_type T_ASS2  = 6'd6;
   localparam opnd_type T_AVV2  = 6'd7;
   localparam opnd_type T_AS    = 6'd8;
   localparam opnd_type T_AV    = 6'd9;
   localparam opnd_type T_AMIX  = 6'd10;
   localparam opnd_type T_CIM   = 6'd11;
   localparam opnd_type T_CIP   = 6'd12;
   localparam opnd_type T_CJM   = 6'd13;
   localparam opnd_type T_CJP   = 6'd14;
   localparam opnd_type T_DGS   = 6'd15;
   localparam opnd_type T_CDG   = 6'd16;
   localparam opnd_type T_CMX   = 6'd17;
   localparam opnd_type T_NCMX  = 6'd18;
   localparam opnd_type T_W1    = 6'd19;
   localparam opnd_type T_W2    = 6'd20;
   localparam opnd_type T_ADVS  = 6'd21;
   localparam opnd_type T_ADVV  = 6'd22;
   localparam opnd_type T_NADVS = 6'd23;
   localparam opnd_type T_SDG   = 6'd24;
   localparam opnd_type T_NONE  = 6'd31;
   // fixed sources
   localparam opnd_type S_ONE   = 6'd32;
   localparam opnd_type S_HALF  = 6'd33;
   localparam opnd_type S_TWO   = 6'd34;
   localparam opnd_type S_RATE  = 6'd35;
   localparam opnd_type S_KAPPA = 6'd36;
   localparam opnd_type S_THETA = 6'd37;
   localparam opnd_type S_XI    = 6'd38;
   localparam opnd_type S_RHO   = 6'd39;
   localparam opnd_type S_SL    = 6'd40;
   localparam opnd_type S_SH    = 6'd41;
   localparam opnd_type S_SR    = 6'd42;
   localparam opnd_type S_VB    = 6'd43;
   localparam opnd_type S_VH    = 6'd44;
   localparam opnd_type S_VA    = 6'd45;

   localparam logic [6:0] PC_BOUND = 7'd0;
   localparam logic [6:0] PC_SOUTH = 7'd1;
   localparam logic [6:0] PC_INT   = 7'd13;

   typedef struct packed {
      alu_op_type op;
      opnd_type   dst;
      opnd_type   src_a;
      opnd_type   src_b;
      col_type    col;
      logic       last;
   } uop_type;

   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [63:0] a;
      logic [63:0] b;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic [10:0] nodes_s;
      logic [10:0] nodes_v;
      logic [63:0] rate;
      logic [63:0] reversion_speed;
      logic [63:0] long_run_variance;
      logic [63:0] vol_of_vol;
      logic [33:0] correlation;
   } cfg_type;

   function automatic logic [63:0] fx_mag(input logic [63:0] x);
      return x[63] ? (~x + 64'd1) : x;
   endfunction

   // apply sign to a magnitude, clip to the signed range
   function automatic logic [63:0] fx_sat(input logic neg, input logic [63:0] m,
                                          input logic big);
      logic [63:0] r;
      if (neg) begin
         r = (big || m[63]) ? SAT_MIN : (~m + 64'd1);
      end else begin
         r = (big || m[63]) ? SAT_MAX : m;
      end
      return r;
   endfunction

   function automatic logic [63:0] fx_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? SAT_MIN : SAT_MAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] fx_neg(input logic [63:0] a);
      return (a == SAT_MIN) ? SAT_MAX : (~a + 64'd1);
   endfunction

   function automatic uop_type mk_uop(input alu_op_type op, input opnd_type dst,
                                      input opnd_type a, input opnd_type b,
                                      input col_type col, input logic last);
      uop_type u;
      u.op    = op;
      u.dst   = dst;
      u.src_a = a;
      u.src_b = b;
      u.col   = col;
      u.last  = last;
      return u;
   endfunction

   // microprogram: border row, south row, interior row
   function automatic uop_type uop_rom(input logic [6:0] pc);
      uop_type u;
      case (pc)
         7'd0:  u = mk_uop(OP_EMIT, T_NONE, S_ONE, S_ONE, COL_C, 1'b1);
         7'd1:  u = mk_uop(OP_MUL, T_W1, S_RATE, S_SH, COL_C, 1'b0);
         7'd2:  u = mk_uop(OP_SUB, T_W2, S_SH, S_SL, COL_C, 1'b0);
         7'd3:  u = mk_uop(OP_DIV, T_ADVS, T_W1, T_W2, COL_C, 1'b0);
         7'd4:  u = mk_uop(OP_MUL, T_W1, S_KAPPA, S_THETA, COL_C, 1'b0);
         7'd5:  u = mk_uop(OP_SUB, T_W2, S_VA, S_VH, COL_C, 1'b0);
         7'd6:  u = mk_uop(OP_DIV, T_ADVV, T_W1, T_W2, COL_C, 1'b0);
         7'd7:  u = mk_uop(OP_NEG, T_NADVS, T_ADVS, T_ADVS, COL_C, 1'b0);
         7'd8:  u = mk_uop(OP_SUB, T_W1, T_ADVS, T_ADVV, COL_C, 1'b0);
         7'd9:  u = mk_uop(OP_SUB, T_SDG, T_W1, S_RATE, COL_C, 1'b0);
         7'd10: u = mk_uop(OP_EMIT, T_NONE, T_NADVS, T_NADVS, COL_L, 1'b0);
         7'd11: u = mk_uop(OP_EMIT, T_NONE, T_SDG, T_SDG, COL_C, 1'b0);
         7'd12: u = mk_uop(OP_EMIT, T_NONE, T_ADVV, T_ADVV, COL_A, 1'b1);
         7'd13: u = mk_uop(OP_SUB, T_HSM, S_SH, S_SL, COL_C, 1'b0);
         7'd14: u = mk_uop(OP_SUB, T_HSP, S_SR, S_SH, COL_C, 1'b0);
         7'd15: u = mk_uop(OP_SUB, T_HVM, S_VH, S_VB, COL_C, 1'b0);
         7'd16: u = mk_uop(OP_SUB, T_HVP, S_VA, S_VH, COL_C, 1'b0);
         7'd17: u = mk_uop(OP_ADD, T_DS, T_HSM, T_HSP, COL_C, 1'b0);
         7'd18: u = mk_uop(OP_ADD, T_DV, T_HVM, T_HVP, COL_C, 1'b0);
         7'd19: u = mk_uop(OP_MUL, T_W1, S_VH, S_SH, COL_C, 1'b0);
         7'd20: u = mk_uop(OP_MUL, T_W1, T_W1, S_SH, COL_C, 1'b0);
         7'd21: u = mk_uop(OP_MUL, T_W1, S_HALF, T_W1, COL_C, 1'b0);
         7'd22: u = mk_uop(OP_MUL, T_ASS2, S_TWO, T_W1, COL_C, 1'b0);
         7'd23: u = mk_uop(OP_MUL, T_W1, S_XI, S_XI, COL_C, 1'b0);
         7'd24: u = mk_uop(OP_MUL, T_W1, T_W1, S_VH, COL_C, 1'b0);
         7'd25: u = mk_uop(OP_MUL, T_W1, S_HALF, T_W1, COL_C, 1'b0);
         7'd26: u = mk_uop(OP_MUL, T_AVV2, S_TWO, T_W1, COL_C, 1'b0);
         7'd27: u = mk_uop(OP_MUL, T_AS, S_RATE, S_SH, COL_C, 1'b0);
         7'd28: u = mk_uop(OP_SUB, T_W1, S_THETA, S_VH, COL_C, 1'b0);
         7'd29: u = mk_uop(OP_MUL, T_AV, S_KAPPA, T_W1, COL_C, 1'b0);
         7'd30: u = mk_uop(OP_MUL, T_W1, S_RHO, S_XI, COL_C, 1'b0);
         7'd31: u = mk_uop(OP_MUL, T_W1, T_W1, S_VH, COL_C, 1'b0);
         7'd32: u = mk_uop(OP_MUL, T_AMIX, T_W1, S_SH, COL_C, 1'b0);
         7'd33: u = mk_uop(OP_MUL, T_W1, T_AS, T_HSP, COL_C, 1'b0);
         7'd34: u = mk_uop(OP_SUB, T_W1, T_ASS2, T_W1, COL_C, 1'b0);
         7'd35: u = mk_uop(OP_DIV, T_W1, T_W1, T_HSM, COL_C, 1'b0);
         7'd36: u = mk_uop(OP_DIV, T_CIM, T_W1, T_DS, COL_C, 1'b0);
         7'd37: u = mk_uop(OP_MUL, T_W1, T_AS, T_HSM, COL_C, 1'b0);
         7'd38: u = mk_uop(OP_ADD, T_W1, T_ASS2, T_W1, COL_C, 1'b0);
         7'd39: u = mk_uop(OP_DIV, T_W1, T_W1, T_HSP, COL_C, 1'b0);
         7'd40: u = mk_uop(OP_DIV, T_CIP, T_W1, T_DS, COL_C, 1'b0);
         7'd41: u = mk_uop(OP_MUL, T_W1, T_AV, T_HVP, COL_C, 1'b0);
         7'd42: u = mk_uop(OP_SUB, T_W1, T_AVV2, T_W1, COL_C, 1'b0);
         7'd43: u = mk_uop(OP_DIV, T_W1, T_W1, T_HVM, COL_C, 1'b0);
         7'd44: u = mk_uop(OP_DIV, T_CJM, T_W1, T_DV, COL_C, 1'b0);
         7'd45: u = mk_uop(OP_MUL, T_W1, T_AV, T_HVM, COL_C, 1'b0);
         7'd46: u = mk_uop(OP_ADD, T_W1, T_AVV2, T_W1, COL_C, 1'b0);
         7'd47: u = mk_uop(OP_DIV, T_W1, T_W1, T_HVP, COL_C, 1'b0);
         7'd48: u = mk_uop(OP_DIV, T_CJP, T_W1, T_DV, COL_C, 1'b0);
         7'd49: u = mk_uop(OP_SUB, T_W1, T_HSP, T_HSM, COL_C, 1'b0);
         7'd50: u = mk_uop(OP_MUL, T_W1, T_AS, T_W1, COL_C, 1'b0);
         7'd51: u = mk_uop(OP_NEG, T_W2, T_ASS2, T_ASS2, COL_C, 1'b0);
         7'd52: u = mk_uop(OP_ADD, T_W1, T_W2, T_W1, COL_C, 1'b0);
         7'd53: u = mk_uop(OP_DIV, T_W1, T_W1, T_HSM, COL_C, 1'b0);
         7'd54: u = mk_uop(OP_DIV, T_DGS, T_W1, T_HSP, COL_C, 1'b0);
         7'd55: u = mk_uop(OP_SUB, T_W1, T_HVP, T_HVM, COL_C, 1'b0);
         7'd56: u = mk_uop(OP_MUL, T_W1, T_AV, T_W1, COL_C, 1'b0);
         7'd57: u = mk_uop(OP_NEG, T_W2, T_AVV2, T_AVV2, COL_C, 1'b0);
         7'd58: u = mk_uop(OP_ADD, T_W1, T_W2, T_W1, COL_C, 1'b0);
         7'd59: u = mk_uop(OP_DIV, T_W1, T_W1, T_HVM, COL_C, 1'b0);
         7'd60: u = mk_uop(OP_DIV, T_W1, T_W1, T_HVP, COL_C, 1'b0);
         7'd61: u = mk_uop(OP_ADD, T_W1, T_DGS, T_W1, COL_C, 1'b0);
         7'd62: u = mk_uop(OP_SUB, T_CDG, T_W1, S_RATE, COL_C, 1'b0);
         7'd63: u = mk_uop(OP_DIV, T_W1, T_AMIX, T_DS, COL_C, 1'b0);
         7'd64: u = mk_uop(OP_DIV, T_CMX, T_W1, T_DV, COL_C, 1'b0);
         7'd65: u = mk_uop(OP_NEG, T_NCMX, T_CMX, T_CMX, COL_C, 1'b0);
         7'd66: u = mk_uop(OP_EMIT, T_NONE, T_CMX, T_CMX, COL_BL, 1'b0);
         7'd67: u = mk_uop(OP_EMIT, T_NONE, T_CJM, T_CJM, COL_B, 1'b0);
         7'd68: u = mk_uop(OP_EMIT, T_NONE, T_NCMX, T_NCMX, COL_BR, 1'b0);
         7'd69: u = mk_uop(OP_EMIT, T_NONE, T_CIM, T_CIM, COL_L, 1'b0);
         7'd70: u = mk_uop(OP_EMIT, T_NONE, T_CDG, T_CDG, COL_C, 1'b0);
         7'd71: u = mk_uop(OP_EMIT, T_NONE, T_CIP, T_CIP, COL_R, 1'b0);
         7'd72: u = mk_uop(OP_EMIT, T_NONE, T_NCMX, T_NCMX, COL_AL, 1'b0);
         7'd73: u = mk_uop(OP_EMIT, T_NONE, T_CJP, T_CJP, COL_A, 1'b0);
         7'd74: u = mk_uop(OP_EMIT, T_NONE, T_CMX, T_CMX, COL_AR, 1'b1);
         default: u = mk_uop(OP_EMIT, T_NONE, S_ONE, S_ONE, COL_C, 1'b1);
      endcase
      return u;
   endfunction

endpackage

// File: rtl/psra_ifs.sv
`timescale 1ns / 1ps
interface psra_req_if;
   logic        valid;
   logic        ready;
   logic [9:0]  col_idx;
   logic [9:0]  row_idx;
   logic [62:0] s_left;
   logic [62:0] s_here;
   logic [62:0] s_right;
   logic [62:0] v_below;
   logic [62:0] v_here;
   logic [62:0] v_above;

   modport source (output valid, col_idx, row_idx, s_left, s_here, s_right,
                   v_below, v_here, v_above, input ready);
   modport sink (input valid, col_idx, row_idx, s_left, s_here, s_right,
                 v_below, v_here, v_above, output ready);
endinterface

interface psra_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] matrix_row;
   logic [19:0] matrix_col;
   logic [63:0] entry_value;
   logic [23:0] row_start;
   logic [23:0] count_after;
   logic        last;

   modport source (output valid, matrix_row, matrix_col, entry_value, row_start,
                   count_after, last, input ready);
   modport sink (input valid, matrix_row, matrix_col, entry_value, row_start,
                 count_after, last, output ready);
endinterface

// File: rtl/pde_stencil_row_assembler_core.sv
`timescale 1ns / 1ps
// Per node: a border row emits one entry, a south row three and an interior row nine. An interior
// row runs 14 divisions on the shared restoring divider, 19 multiplies and 20 add, subtract or
// negate steps; each entry is loaded into the output register once it is empty or being taken.
// Throughput: one node at a time; the next node is taken after the last entry is loaded.
// Reset: synchronous, active high; clears the sequencer, entry count and config registers (node counts to 1024).
module pde_stencil_row_assembler_core (
   input  logic        clock,
   input  logic        reset,
   psra_req_if.sink    req_chan,
   psra_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import psra_pkg::*;

   cfg_type       cfg;
   alu_req_type   alu_req;
   alu_rsp_type   alu_rsp;
   seq_state_type state_ff, state_in;
   logic [6:0]    pc_ff, pc_in, row_pc;
   uop_type       uop_ff, uop_in, uop_rd;
   logic [23:0]   count_ff, count_in, count_base, start_ff;
   logic [9:0]    ix_ff, iy_ff;
   logic [62:0]   sl_ff, sh_ff, sr_ff, vb_ff, vh_ff, va_ff;
   logic [10:0]   ns_c, nv_c, ns_ff;
   logic [20:0]   node_prod;
   logic [19:0]   node_c, node_ff, col_base, col_val;
   logic [3:0]    row_len;
   logic          in_grid, at_origin, req_ready, rsp_load;
   logic [63:0]   tmp_mem [32];
   logic [63:0]   rd_a_ff, rd_b_ff;
   opnd_type      codes [2];
   logic [63:0]   rdata [2];
   logic [63:0]   opnd [2];
   logic          rsp_valid_ff, rsp_last_ff;
   logic [19:0]   rsp_row_ff, rsp_col_ff;
   logic [63:0]   rsp_val_ff;
   logic [23:0]   rsp_start_ff, rsp_after_ff;

   psra_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   psra_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .alu_req(alu_req),
      .alu_rsp(alu_rsp)
   );

   // classify the latched node
   always_comb begin
      ns_c = (cfg.nodes_s == 11'd0) ? 11'd1 : ((cfg.nodes_s > NS_MAX) ? NS_MAX : cfg.nodes_s);
      nv_c = (cfg.nodes_v == 11'd0) ? 11'd1 : ((cfg.nodes_v > NV_MAX) ? NV_MAX : cfg.nodes_v);
      at_origin = (ix_ff == 10'd0) && (iy_ff == 10'd0);
      in_grid   = ({1'b0, ix_ff} < ns_c) && ({1'b0, iy_ff} < nv_c);
      node_prod = iy_ff * ns_c;
      node_c    = node_prod[19:0] + {10'd0, ix_ff};
      if (ix_ff == 10'd0 || {1'b0, ix_ff} == ns_c - 11'd1 || {1'b0, iy_ff} == nv_c - 11'd1) begin
         row_pc  = PC_BOUND;
         row_len = 4'd1;
      end else if (iy_ff == 10'd0) begin
         row_pc  = PC_SOUTH;
         row_len = 4'd3;
      end else begin
         row_pc  = PC_INT;
         row_len = 4'd9;
      end
      count_base = at_origin ? 24'd0 : count_ff;
   end

   // operand select: scratch slot or fixed source
   always_comb begin
      codes[0] = uop_ff.src_a;
      codes[1] = uop_ff.src_b;
      rdata[0] = rd_a_ff;
      rdata[1] = rd_b_ff;
      for (int k = 0; k < 2; k++) begin
         case (codes[k])
            S_ONE:   opnd[k] = FX_ONE;
            S_HALF:  opnd[k] = FX_HALF;
            S_TWO:   opnd[k] = FX_TWO;
            S_RATE:  opnd[k] = cfg.rate;
            S_KAPPA: opnd[k] = cfg.reversion_speed;
            S_THETA: opnd[k] = cfg.long_run_variance;
            S_XI:    opnd[k] = cfg.vol_of_vol;
            S_RHO:   opnd[k] = {{30{cfg.correlation[33]}}, cfg.correlation};
            S_SL:    opnd[k] = {1'b0, sl_ff};
            S_SH:    opnd[k] = {1'b0, sh_ff};
            S_SR:    opnd[k] = {1'b0, sr_ff};
            S_VB:    opnd[k] = {1'b0, vb_ff};
            S_VH:    opnd[k] = {1'b0, vh_ff};
            S_VA:    opnd[k] = {1'b0, va_ff};
            default: opnd[k] = rdata[k];
         endcase
      end
   end

   // column of the entry being emitted
   always_comb begin
      case (uop_ff.col)
         COL_BL, COL_B, COL_BR: col_base = node_ff - {9'd0, ns_ff};
         COL_AL, COL_A, COL_AR: col_base = node_ff + {9'd0, ns_ff};
         default:               col_base = node_ff;
      endcase
      case (uop_ff.col)
         COL_BL, COL_L, COL_AL: col_val = col_base - 20'd1;
         COL_BR, COL_R, COL_AR: col_val = col_base + 20'd1;
         default:               col_val = col_base;
      endcase
   end

   // sequencer
   always_comb begin
      uop_rd      = uop_rom(pc_ff);
      state_in    = state_ff;
      pc_in       = pc_ff;
      uop_in      = uop_ff;
      count_in    = count_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      alu_req     = '0;
      alu_req.op  = uop_ff.op;
      alu_req.a   = opnd[0];
      alu_req.b   = opnd[1];
      case (state_ff)
         SQ_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               state_in = SQ_DECODE;
            end
         end
         SQ_DECODE: begin
            count_in = count_base;
            if (in_grid) begin
               count_in = count_base + {20'd0, row_len};
               pc_in    = row_pc;
               state_in = SQ_FETCH;
            end else begin
               state_in = SQ_IDLE;
            end
         end
         SQ_FETCH: begin
            uop_in   = uop_rd;
            state_in = SQ_OPER;
         end
         SQ_OPER: begin
            if (uop_ff.op == OP_EMIT) begin
               state_in = SQ_EMIT;
            end else begin
               alu_req.start = 1'b1;
               state_in      = SQ_WAIT;
            end
         end
         SQ_WAIT: begin
            if (alu_rsp.done) begin
               pc_in    = pc_ff + 7'd1;
               state_in = SQ_FETCH;
            end
         end
         SQ_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               if (uop_ff.last) begin
                  state_in = SQ_IDLE;
               end else begin
                  pc_in    = pc_ff + 7'd1;
                  state_in = SQ_FETCH;
               end
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         pc_ff        <= PC_BOUND;
         uop_ff       <= '0;
         count_ff     <= 24'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         uop_ff   <= uop_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture the node and its row geometry
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         ix_ff <= req_chan.col_idx;
         iy_ff <= req_chan.row_idx;
         sl_ff <= req_chan.s_left;
         sh_ff <= req_chan.s_here;
         sr_ff <= req_chan.s_right;
         vb_ff <= req_chan.v_below;
         vh_ff <= req_chan.v_here;
         va_ff <= req_chan.v_above;
      end
      if (state_ff == SQ_DECODE) begin
         ns_ff    <= ns_c;
         node_ff  <= node_c;
         start_ff <= count_base;
      end
   end

   // scratch memory: write on unit completion, two registered reads
   always_ff @(posedge clock) begin
      if (state_ff == SQ_WAIT && alu_rsp.done) begin
         tmp_mem[uop_ff.dst[4:0]] <= alu_rsp.result;
      end
      rd_a_ff <= tmp_mem[uop_rd.src_a[4:0]];
      rd_b_ff <= tmp_mem[uop_rd.src_b[4:0]];
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff   <= node_ff;
         rsp_col_ff   <= col_val;
         rsp_val_ff   <= opnd[0];
         rsp_start_ff <= start_ff;
         rsp_after_ff <= count_ff;
         rsp_last_ff  <= uop_ff.last;
      end
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.matrix_row  = rsp_row_ff;
   assign rsp_chan.matrix_col  = rsp_col_ff;
   assign rsp_chan.entry_value = rsp_val_ff;
   assign rsp_chan.row_start   = rsp_start_ff;
   assign rsp_chan.count_after = rsp_after_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == SQ_WAIT)
      else $error("arithmetic unit finished outside wait state");

   a_start_in_oper: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> state_ff == SQ_OPER && uop_ff.op != OP_EMIT)
      else $error("arithmetic unit started outside operand state");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load && uop_ff.last |=> state_ff == SQ_IDLE && rsp_valid_ff && rsp_last_ff)
      else $error("row did not close on its last entry");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != SQ_IDLE |-> !req_chan.ready)
      else $error("node taken while a row is in progress");
`endif

endmodule

// File: rtl/psra_csr.sv
`timescale 1ns / 1ps
module psra_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [5:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready,
   output psra_pkg::cfg_type cfg
);
   import psra_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type sel;

   // decode the write
   always_comb begin
      sel    = csr_reg_type'(csr_paddr[5:3]);
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (sel)
            REG_NODES_S: cfg_in.nodes_s           = csr_pwdata[10:0];
            REG_NODES_V: cfg_in.nodes_v           = csr_pwdata[10:0];
            REG_RATE:    cfg_in.rate              = csr_pwdata;
            REG_KAPPA:   cfg_in.reversion_speed   = csr_pwdata;
            REG_THETA:   cfg_in.long_run_variance = csr_pwdata;
            REG_XI:      cfg_in.vol_of_vol        = csr_pwdata;
            REG_RHO:     cfg_in.correlation       = csr_pwdata[33:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (sel)
         REG_NODES_S: csr_prdata = {53'd0, cfg_ff.nodes_s};
         REG_NODES_V: csr_prdata = {53'd0, cfg_ff.nodes_v};
         REG_RATE:    csr_prdata = cfg_ff.rate;
         REG_KAPPA:   csr_prdata = cfg_ff.reversion_speed;
         REG_THETA:   csr_prdata = cfg_ff.long_run_variance;
         REG_XI:      csr_prdata = cfg_ff.vol_of_vol;
         REG_RHO:     csr_prdata = {{30{cfg_ff.correlation[33]}}, cfg_ff.correlation};
         default:     csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '0;
         cfg_ff.nodes_s <= 11'd1024;
         cfg_ff.nodes_v <= 11'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// File: rtl/psra_alu.sv
`timescale 1ns / 1ps
module psra_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  psra_pkg::alu_req_type alu_req,
   output psra_pkg::alu_rsp_type alu_rsp
);
   import psra_pkg::*;

   alu_state_type state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic          done_ff, done_in;
   logic [63:0]   x_ff, x_in, y_ff, y_in, pp_ff, pp_in;
   logic [63:0]   rem_ff, rem_in, lo_ff, lo_in, q_ff, q_in, res_ff, res_in;
   logic [127:0]  acc_ff, acc_in, pp_sh;
   logic [63:0]   a_mag, b_mag, a_hi, q_next;
   logic [31:0]   xh, yh;
   logic [1:0]    pk;
   logic [64:0]   rem_sh, rem_sub;
   logic          take;

   always_comb begin
      a_mag   = fx_mag(alu_req.a);
      b_mag   = fx_mag(alu_req.b);
      a_hi    = a_mag >> (64 - FRAC_BITS);
      // partial product select: x half by pk[1], y half by pk[0]
      pk      = cnt_ff[2:1];
      xh      = pk[1] ? x_ff[63:32] : x_ff[31:0];
      yh      = pk[0] ? y_ff[63:32] : y_ff[31:0];
      case (pk)
         2'd0:    pp_sh = {64'd0, pp_ff};
         2'd3:    pp_sh = {pp_ff, 64'd0};
         default: pp_sh = {32'd0, pp_ff, 32'd0};
      endcase
      // one restoring division step
      rem_sh  = {rem_ff, lo_ff[63]};
      rem_sub = rem_sh - {1'b0, y_ff};
      take    = (rem_sh >= {1'b0, y_ff});
      q_next  = {q_ff[62:0], take};

      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      done_in  = 1'b0;

      case (state_ff)
         ALU_IDLE: begin
            if (alu_req.start) begin
               neg_in = alu_req.a[63] ^ alu_req.b[63];
               cnt_in = 6'd0;
               case (alu_req.op)
                  OP_ADD: begin
                     res_in  = fx_add(alu_req.a, alu_req.b);
                     done_in = 1'b1;
                  end
                  OP_SUB: begin
                     res_in  = fx_add(alu_req.a, fx_neg(alu_req.b));
                     done_in = 1'b1;
                  end
                  OP_NEG: begin
                     res_in  = fx_neg(alu_req.a);
                     done_in = 1'b1;
                  end
                  OP_MUL: begin
                     x_in     = a_mag;
                     y_in     = b_mag;
                     acc_in   = '0;
                     state_in = ALU_MUL;
                  end
                  OP_DIV: begin
                     if (a_mag == 64'd0) begin
                        res_in  = 64'd0;
                        done_in = 1'b1;
                     end else if (b_mag == 64'd0) begin
                        res_in  = alu_req.a[63] ? SAT_MIN : SAT_MAX;
                        done_in = 1'b1;
                     end else if (a_hi >= b_mag) begin
                        res_in  = (alu_req.a[63] ^ alu_req.b[63]) ? SAT_MIN : SAT_MAX;
                        done_in = 1'b1;
                     end else begin
                        rem_in   = a_hi;
                        lo_in    = a_mag << FRAC_BITS;
                        y_in     = b_mag;
                        q_in     = 64'd0;
                        state_in = ALU_DIV;
                     end
                  end
                  default: begin
                     res_in  = 64'd0;
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         ALU_MUL: begin
            // even cycle: multiply a half pair; odd cycle: accumulate it
            if (!cnt_ff[0]) begin
               pp_in = xh * yh;
            end else begin
               acc_in = acc_ff + pp_sh;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd7) begin
               state_in = ALU_MFIN;
            end
         end
         ALU_MFIN: begin
            res_in   = fx_sat(neg_ff, acc_ff[FRAC_BITS+63:FRAC_BITS],
                              |acc_ff[127:FRAC_BITS+64]);
            done_in  = 1'b1;
            state_in = ALU_IDLE;
         end
         ALU_DIV: begin
            rem_in = take ? rem_sub[63:0] : rem_sh[63:0];
            lo_in  = lo_ff << 1;
            q_in   = q_next;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               res_in   = fx_sat(neg_ff, q_next, 1'b0);
               done_in  = 1'b1;
               state_in = ALU_IDLE;
            end
         end
         default: state_in = ALU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // hold datapath operands
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = res_ff;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import psra_pkg::*;

   typedef logic signed [63:0] fx_t;

   typedef struct {
      logic [9:0]  col;
      logic [9:0]  row;
      logic [62:0] sl, sh, sr, vb, vh, va;
   } grid_node_t;

   typedef struct {
      logic [19:0] mrow;
      logic [19:0] mcol;
      logic [63:0] value;
      logic [23:0] start;
      logic [23:0] after;
      logic        last;
   } matrix_entry_t;

   localparam int QUIET_LIMIT = 40000;
   localparam int SETTLE      = 1500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   psra_req_if req_if();
   psra_rsp_if rsp_if();

   pde_stencil_row_assembler_core dut (
      .clock(clock), .reset(reset), .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // shadow of the block state
   logic [10:0] shadow_ns = 11'd1024, shadow_nv = 11'd1024;
   fx_t         shadow_rate = 0, shadow_kappa = 0, shadow_theta = 0, shadow_xi = 0;
   fx_t         shadow_rho = 0;
   logic [23:0] shadow_count = '0;

   matrix_entry_t pending_entries[$];
   int          error_count = 0;
   int          send_idle = 26, rsp_idle = 75;
   int          quiet_cycles = 0;

   // ---------------- fixed-point arithmetic ----------------
   function automatic logic [63:0] fx_abs(fx_t a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   function automatic fx_t fx_clip(logic neg, logic [63:0] m, logic big);
      if (neg) return (big || m[63]) ? fx_t'(SAT_MIN) : -fx_t'(m);
      return (big || m[63]) ? fx_t'(SAT_MAX) : fx_t'(m);
   endfunction

   function automatic fx_t fx_plus(fx_t a, fx_t b);
      fx_t s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? fx_t'(SAT_MIN) : fx_t'(SAT_MAX);
      return s;
   endfunction

   function automatic fx_t fx_negate(fx_t a);
      return (a == fx_t'(SAT_MIN)) ? fx_t'(SAT_MAX) : -a;
   endfunction

   function automatic fx_t fx_minus(fx_t a, fx_t b);
      return fx_plus(a, fx_negate(b));
   endfunction

   function automatic fx_t fx_times(fx_t a, fx_t b);
      logic [127:0] p;
      p = {64'd0, fx_abs(a)} * {64'd0, fx_abs(b)};
      return fx_clip(a[63] ^ b[63], p[95:32], |p[127:96]);
   endfunction

   function automatic fx_t fx_over(fx_t a, fx_t b);
      logic [63:0]  x, d;
      logic [127:0] q;
      x = fx_abs(a);
      d = fx_abs(b);
      if (x == 0) return 0;
      if (d == 0) return fx_clip(a[63], 64'd0, 1'b1);
      if ((x >> 32) >= d) return fx_clip(a[63] ^ b[63], 64'd0, 1'b1);
      q = {x, 64'd0} >> 32;
      q = q / {64'd0, d};
      return fx_clip(a[63] ^ b[63], q[63:0], 1'b0);
   endfunction

   function automatic int clamp_nodes(logic [10:0] n);
      if (n == 0) return 1;
      return (n > 11'd1024) ? 1024 : int'(n);
   endfunction

   // work out the operator row of one node and queue its entries
   task automatic predict_stencil_row(input grid_node_t n);
      int            ns, nv, ix, iy, node, cnt, below, above;
      fx_t           sl, s, sr, vb, v, va, one, half;
      fx_t           hsm, hsp, hvm, hvp, ds, dv, ass2, avv2, a_s, a_v, amix;
      fx_t           advs, advv, cim, cip, cjm, cjp, dgs, dgv, cdg, cmx;
      fx_t           vals[9];
      int            cols[9];
      logic [23:0]   start;
      matrix_entry_t e;
      ns = clamp_nodes(shadow_ns);
      nv = clamp_nodes(shadow_nv);
      ix = n.col;
      iy = n.row;
      one = fx_t'(FX_ONE);
      half = one >>> 1;
      if (ix == 0 && iy == 0) shadow_count = '0;
      if (ix >= ns || iy >= nv) return;
      node = iy * ns + ix;
      sl = {1'b0, n.sl}; s = {1'b0, n.sh}; sr = {1'b0, n.sr};
      vb = {1'b0, n.vb}; v = {1'b0, n.vh}; va = {1'b0, n.va};
      if (ix == 0 || ix == ns - 1 || iy == nv - 1) begin
         cols[0] = node; vals[0] = one; cnt = 1;
      end else if (iy == 0) begin
         advs = fx_over(fx_times(shadow_rate, s), s - sl);
         advv = fx_over(fx_times(shadow_kappa, shadow_theta), va - v);
         cols[0] = node - 1;  vals[0] = fx_negate(advs);
         cols[1] = node;      vals[1] = fx_minus(fx_minus(advs, advv), shadow_rate);
         cols[2] = node + ns; vals[2] = advv;
         cnt = 3;
      end else begin
         hsm = s - sl; hsp = sr - s; hvm = v - vb; hvp = va - v;
         ds = fx_plus(hsm, hsp);
         dv = fx_plus(hvm, hvp);
         ass2 = fx_times(one <<< 1, fx_times(half, fx_times(fx_times(v, s), s)));
         avv2 = fx_times(one <<< 1,
                         fx_times(half, fx_times(fx_times(shadow_xi, shadow_xi), v)));
         a_s = fx_times(shadow_rate, s);
         a_v = fx_times(shadow_kappa, fx_minus(shadow_theta, v));
         amix = fx_times(fx_times(fx_times(shadow_rho, shadow_xi), v), s);
         cim = fx_over(fx_over(fx_minus(ass2, fx_times(a_s, hsp)), hsm), ds);
         cip = fx_over(fx_over(fx_plus(ass2, fx_times(a_s, hsm)), hsp), ds);
         cjm = fx_over(fx_over(fx_minus(avv2, fx_times(a_v, hvp)), hvm), dv);
         cjp = fx_over(fx_over(fx_plus(avv2, fx_times(a_v, hvm)), hvp), dv);
         dgs = fx_over(fx_over(fx_plus(fx_negate(ass2), fx_times(a_s, fx_minus(hsp, hsm))),
                               hsm), hsp);
         dgv = fx_over(fx_over(fx_plus(fx_negate(avv2), fx_times(a_v, fx_minus(hvp, hvm))),
                               hvm), hvp);
         cdg = fx_minus(fx_plus(dgs, dgv), shadow_rate);
         cmx = fx_over(fx_over(amix, ds), dv);
         below = node - ns;
         above = node + ns;
         cols[0] = below - 1; vals[0] = cmx;
         cols[1] = below;     vals[1] = cjm;
         cols[2] = below + 1; vals[2] = fx_negate(cmx);
         cols[3] = node - 1;  vals[3] = cim;
         cols[4] = node;      vals[4] = cdg;
         cols[5] = node + 1;  vals[5] = cip;
         cols[6] = above - 1; vals[6] = fx_negate(cmx);
         cols[7] = above;     vals[7] = cjp;
         cols[8] = above + 1; vals[8] = cmx;
         cnt = 9;
      end
      start = shadow_count;
      shadow_count = shadow_count + 24'(cnt);
      for (int k = 0; k < cnt; k++) begin
         e.mrow = 20'(node);
         e.mcol = 20'(cols[k]);
         e.value = vals[k];
         e.start = start;
         e.after = shadow_count;
         e.last = (k == cnt - 1);
         pending_entries.push_back(e);
      end
   endtask

   // ---------------- drivers ----------------
   // call just after a falling edge; returns just after a falling edge
   task automatic send_node(input grid_node_t n);
      while ($urandom_range(0, 99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.col_idx <= n.col;  req_if.row_idx <= n.row;
      req_if.s_left <= n.sl;    req_if.s_here <= n.sh;   req_if.s_right <= n.sr;
      req_if.v_below <= n.vb;   req_if.v_here <= n.vh;   req_if.v_above <= n.va;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predict_stencil_row(n);
      @(negedge clock);
   endtask

   // drop valid and hold until every expected entry has come, then let the block settle
   task automatic wait_idle(input int settle);
      req_if.valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type r, input logic [63:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {r, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (r)
         REG_NODES_S: shadow_ns = value[10:0];
         REG_NODES_V: shadow_nv = value[10:0];
         REG_RATE:    shadow_rate = value;
         REG_KAPPA:   shadow_kappa = value;
         REG_THETA:   shadow_theta = value;
         REG_XI:      shadow_xi = value;
         REG_RHO:     shadow_rho = {{30{value[33]}}, value[33:0]};
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic grid_node_t mk_node(int ix, int iy, logic [62:0] s, logic [62:0] hs,
                                          logic [62:0] v, logic [62:0] hv);
      grid_node_t n;
      n.col = 10'(ix); n.row = 10'(iy);
      n.sl = s - hs; n.sh = s; n.sr = s + hs;
      n.vb = v - hv; n.vh = v; n.va = v + hv;
      return n;
   endfunction

   function automatic logic [62:0] rand63();
      return 63'({$urandom, $urandom});
   endfunction

   // mostly ordered coordinates with random spacing, sometimes raw noise
   function automatic grid_node_t rand_node(int ns, int nv);
      grid_node_t n;
      logic [62:0] s, v;
      n.col = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, ns - 1));
      n.row = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, nv - 1));
      if ($urandom_range(0, 4) == 0) begin
         n.sl = rand63(); n.sh = rand63(); n.sr = rand63();
         n.vb = rand63(); n.vh = rand63(); n.va = rand63();
      end else begin
         s = 63'({$urandom_range(4, 200), $urandom});
         v = 63'({$urandom_range(2, 8), $urandom});
         n.sh = s;
         n.sl = s - 63'({$urandom_range(0, 3), $urandom});
         n.sr = s + 63'({$urandom_range(0, 3), $urandom});
         n.vh = v;
         n.vb = v - 63'({$urandom_range(0, 1), $urandom});
         n.va = v + 63'({$urandom_range(0, 1), $urandom});
      end
      return n;
   endfunction

   function automatic logic [63:0] rand_param();
      fx_t p;
      case ($urandom_range(0, 7))
         0: p = fx_t'(SAT_MAX);
         1: p = fx_t'(SAT_MIN);
         default: begin
            p = {$urandom_range(0, 2), $urandom};
            if ($urandom_range(0, 1)) p = -p;
         end
      endcase
      return p;
   endfunction

   function automatic logic [63:0] rand_corr();
      fx_t p;
      p = {$urandom_range(0, 1), $urandom};
      if (p > fx_t'(FX_ONE)) p = fx_t'(FX_ONE);
      if ($urandom_range(0, 1)) p = -p;
      return p;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(negedge clock) rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle);

   always @(posedge clock) begin
      matrix_entry_t e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_entries.size() == 0) begin
            report_mismatch("unexpected entry col", rsp_if.matrix_col, 0);
         end else begin
            e = pending_entries.pop_front();
            if (rsp_if.matrix_row !== e.mrow)
               report_mismatch("matrix_row", rsp_if.matrix_row, e.mrow);
            if (rsp_if.matrix_col !== e.mcol)
               report_mismatch("matrix_col", rsp_if.matrix_col, e.mcol);
            if (rsp_if.entry_value !== e.value)
               report_mismatch("entry_value", rsp_if.entry_value, e.value);
            if (rsp_if.row_start !== e.start)
               report_mismatch("row_start", rsp_if.row_start, e.start);
            if (rsp_if.count_after !== e.after)
               report_mismatch("count_after", rsp_if.count_after, e.after);
            if (rsp_if.last !== e.last)
               report_mismatch("last", rsp_if.last, e.last);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_reset_values();
      logic [62:0] one;
      one = 63'd1 << 32;
      send_node(mk_node(0, 0, 5 * one, one, 2 * one, one >> 2));
      send_node(mk_node(5, 0, 5 * one, one, 2 * one, one >> 2));
      send_node(mk_node(5, 5, 5 * one, one, 2 * one, one >> 2));
      send_node(mk_node(1023, 7, 5 * one, one, 2 * one, one >> 2));
      send_node(mk_node(7, 1023, 5 * one, one, 2 * one, one >> 2));
   endtask

   task automatic test_row_kinds();
      logic [62:0] one;
      one = 63'd1 << 32;
      wait_idle(SETTLE);
      write_reg(REG_NODES_S, 64'd4);
      write_reg(REG_NODES_V, 64'd3);
      write_reg(REG_RATE, 64'h0000_0000_0CCC_CCCD);
      write_reg(REG_KAPPA, 64'h0000_0002_0000_0000);
      write_reg(REG_THETA, 64'h0000_0000_1000_0000);
      write_reg(REG_XI, 64'h0000_0000_8000_0000);
      write_reg(REG_RHO, 64'hFFFF_FFFF_B000_0000);
      send_node(mk_node(0, 0, 3 * one, one, one, one >> 3));
      send_node(mk_node(1, 1, 3 * one, one, one, one >> 3));
      send_node(mk_node(2, 1, 9 * one, 2 * one, one, one >> 2));
      send_node(mk_node(1, 0, 3 * one, one, one, one >> 3));
      // hold off until the block has drained
      wait_idle(0);
      send_node(mk_node(2, 0, 3 * one, one, one, one >> 3));
      send_node(mk_node(1, 2, 3 * one, one, one, one >> 3));
      send_node(mk_node(3, 1, 3 * one, one, one, one >> 3));
      send_node(mk_node(4, 1, 3 * one, one, one, one >> 3));
      send_node(mk_node(1023, 1023, 3 * one, one, one, one >> 3));
   endtask

   task automatic test_arith_corners();
      grid_node_t n;
      logic [62:0] one;
      one = 63'd1 << 32;
      wait_idle(SETTLE);
      write_reg(REG_RATE, SAT_MAX);
      write_reg(REG_KAPPA, SAT_MIN);
      write_reg(REG_THETA, SAT_MAX);
      write_reg(REG_XI, SAT_MAX);
      write_reg(REG_RHO, FX_ONE);
      // zero spacings everywhere
      send_node(mk_node(1, 1, one, 0, one, 0));
      send_node(mk_node(2, 0, one, 0, one, 0));
      // reversed coordinates
      send_node(mk_node(2, 1, 4 * one, -one, 2 * one, -(one >> 1)));
      // coordinate extremes
      n.col = 10'd1; n.row = 10'd1;
      n.sl = '0; n.sh = '1; n.sr = '0; n.vb = '1; n.vh = '0; n.va = '1;
      send_node(n);
      n.sl = '1; n.sh = '0; n.sr = '1; n.vb = '0; n.vh = '1; n.va = '0;
      send_node(n);
      wait_idle(SETTLE);
      write_reg(REG_RHO, 64'h0000_0002_0000_0000);
      write_reg(REG_XI, SAT_MIN);
      write_reg(REG_RATE, SAT_MIN);
      write_reg(REG_KAPPA, SAT_MAX);
      send_node(mk_node(1, 1, 2 * one, one >> 4, one, one >> 5));
      send_node(mk_node(1, 0, 2 * one, one >> 4, one, one >> 5));
   endtask

   task automatic test_grid_clamp();
      logic [62:0] one;
      one = 63'd1 << 32;
      wait_idle(SETTLE);
      write_reg(REG_NODES_S, 64'd0);
      write_reg(REG_NODES_V, 64'h7FF);
      send_node(mk_node(0, 0, one, one, one, one));
      send_node(mk_node(0, 1023, one, one, one, one));
      wait_idle(SETTLE);
      write_reg(REG_NODES_S, 64'h7FF);
      write_reg(REG_NODES_V, 64'd0);
      send_node(mk_node(1023, 0, one, one, one, one));
      send_node(mk_node(3, 0, one, one, one, one));
   endtask

   task automatic test_random_traffic(input int s_idle, input int r_idle, input int count);
      int ns, nv;
      wait_idle(SETTLE);
      send_idle = s_idle;
      rsp_idle = r_idle;
      ns = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(3, 8);
      nv = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(3, 8);
      write_reg(REG_NODES_S, 64'(ns));
      write_reg(REG_NODES_V, 64'(nv));
      write_reg(REG_RATE, rand_param());
      write_reg(REG_KAPPA, rand_param());
      write_reg(REG_THETA, rand_param());
      write_reg(REG_XI, rand_param());
      write_reg(REG_RHO, rand_corr());
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 24) == 0) wait_idle(0);
         send_node(rand_node(ns, nv));
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.col_idx = '0; req_if.row_idx = '0;
      req_if.s_left = '0; req_if.s_here = '0; req_if.s_right = '0;
      req_if.v_below = '0; req_if.v_here = '0; req_if.v_above = '0;
      rsp_if.ready = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_row_kinds();
      test_arith_corners();
      test_grid_clamp();
      test_random_traffic(26, 75, 42);
      test_random_traffic(75, 26, 42);
      test_random_traffic(0, 0, 42);
      wait_idle(SETTLE);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
